@@ rtl/yald_pkg.sv @@
package yald_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 15;
    localparam int MUL_A_W  = 17;
    localparam int MUL_B_W  = 11;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

    localparam logic [STEP_W-1:0]   STEP_MIN = 15'h007f;
    localparam logic [STEP_W-1:0]   STEP_MAX = 15'h6000;
    localparam logic [MUL_B_W-1:0]  LEAK_NUM = 11'd254;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

    // step multiplier chosen by the code magnitude
    function automatic logic [MUL_B_W-1:0] step_scale(input logic [2:0] mag);
        logic [MUL_B_W-1:0] s;
        begin
            case (mag)
                3'd4:    s = 11'h133;
                3'd5:    s = 11'h199;
                3'd6:    s = 11'h200;
                3'd7:    s = 11'h266;
                default: s = 11'h0e6;
            endcase
            return s;
        end
    endfunction

endpackage

@@ rtl/yamaha_adpcm_leaky_decoder.sv @@
// channel  dir  handshake            payload
// s        in   i_s_tvalid/o_s_tready tdata[7:0] code_byte, tlast last_byte
// m        out  o_m_tvalid/i_m_tready tdata[15:0] pcm_sample, tuser[0] second_of_pair,
//                                     tlast stream_end
// Each byte is decoded low nibble first; per nibble the sequencer runs DIFF, SUM, STEP and LEAK
// for three passes through the shared registered multiplier (difference, step scale, leak)
// and EMIT to hand off the beat, then returns to IDLE for the next byte after the second nibble.
// The input is not ready while a byte is being decoded.
// Synchronous active-low reset returns predictor to 0 and step to 0x7f.
// A stalled output beat holds the sequencer in its emit state.
module yamaha_adpcm_leaky_decoder
    import yald_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] code_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] pcm_sample
    output logic [0:0]  o_m_tuser,   // [0] second_of_pair
    output logic        o_m_tlast
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIFF = 6'b000010,
        S_SUM  = 6'b000100,
        S_STEP = 6'b001000,
        S_LEAK = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [7:0]          r_byte;
    logic                r_last;
    logic                r_nib;
    logic [SAMPLE_W-1:0] r_pred;
    logic [STEP_W-1:0]   r_step;
    logic [SAMPLE_W-1:0] r_sample;

    logic [3:0]                code;
    logic [3:0]                mag;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;

    logic signed [MUL_P_W-1:0] div8_bias;
    logic signed [MUL_P_W-1:0] div8;
    logic signed [17:0]        sum;
    logic [SAMPLE_W-1:0]       sum_sat;
    logic [19:0]               step_raw;
    logic [STEP_W-1:0]         step_clamp;
    logic signed [MUL_P_W-1:0] leak_bias;
    logic signed [MUL_P_W-1:0] leak;

    logic s_beat, m_beat;

    assign s_beat = i_s_tvalid & o_s_tready;
    assign m_beat = o_m_tvalid & i_m_tready;

    assign code = r_nib ? r_byte[7:4] : r_byte[3:0];
    assign mag  = {code[2:0], 1'b1};

    // operand select for the shared multiplier
    always_comb begin
        mul_a = $signed({2'b00, r_step});
        mul_b = '0;
        case (r_state)
            S_DIFF: begin
                mul_b = code[3] ? -$signed({7'd0, mag}) : $signed({7'd0, mag});
            end
            S_SUM: begin
                mul_b = $signed(step_scale(code[2:0]));
            end
            S_STEP: begin
                mul_a = $signed({r_sample[SAMPLE_W-1], r_sample});
                mul_b = $signed(LEAK_NUM);
            end
            default: begin
                mul_b = '0;
            end
        endcase
    end

    yald_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // divide by 8 and by 256 rounding toward zero
    assign div8_bias = prod + (prod[MUL_P_W-1] ? 28'sd7 : 28'sd0);
    assign div8      = div8_bias >>> 3;
    assign sum       = $signed({{2{r_pred[SAMPLE_W-1]}}, r_pred}) + $signed(div8[17:0]);

    always_comb begin
        if (sum > 18'sd32767) begin
            sum_sat = SAMPLE_MAX;
        end else if (sum < -18'sd32768) begin
            sum_sat = SAMPLE_MIN;
        end else begin
            sum_sat = sum[SAMPLE_W-1:0];
        end
    end

    assign step_raw = prod[27:8];

    always_comb begin
        if (step_raw < {5'd0, STEP_MIN}) begin
            step_clamp = STEP_MIN;
        end else if (step_raw > {5'd0, STEP_MAX}) begin
            step_clamp = STEP_MAX;
        end else begin
            step_clamp = step_raw[STEP_W-1:0];
        end
    end

    assign leak_bias = prod + (prod[MUL_P_W-1] ? 28'sd255 : 28'sd0);
    assign leak      = leak_bias >>> 8;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_beat) n_state = S_DIFF;
            S_DIFF: n_state = S_SUM;
            S_SUM:  n_state = S_STEP;
            S_STEP: n_state = S_LEAK;
            S_LEAK: n_state = S_EMIT;
            S_EMIT: begin
                if (m_beat) begin
                    n_state = r_nib ? S_IDLE : S_DIFF;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nib   <= 1'b0;
            r_pred  <= '0;
            r_step  <= STEP_MIN;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_nib <= 1'b0;
                end
                S_STEP: begin
                    r_step <= step_clamp;
                end
                S_LEAK: begin
                    r_pred <= leak[SAMPLE_W-1:0];
                end
                S_EMIT: begin
                    if (m_beat) begin
                        r_nib <= ~r_nib;
                        // end of stream: drop state back to reset values
                        if (r_nib && r_last) begin
                            r_pred <= '0;
                            r_step <= STEP_MIN;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_beat) begin
            r_byte <= i_s_tdata;
            r_last <= i_s_tlast;
        end
        if (r_state == S_SUM) begin
            r_sample <= sum_sat;
        end
    end

    assign o_s_tready   = (r_state == S_IDLE);
    assign o_m_tvalid   = (r_state == S_EMIT);
    assign o_m_tdata    = r_sample;
    assign o_m_tuser[0] = r_nib;
    assign o_m_tlast    = r_nib & r_last;

endmodule

@@ rtl/yald_mul.sv @@
module yald_mul
    import yald_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    logic signed [MUL_P_W-1:0] r_p;
    logic signed [MUL_P_W-1:0] n_p;

    assign n_p = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule
